FILE: src/orf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Reply framer package
// Shared constants, step codes and the fixed key table for the reply framer.
// ----------------------------------------------------------------------------
package orf_pkg;

    localparam int SIZE_W        = 16;
    localparam int BYTE_W        = 8;
    localparam int KEY_IDX_W     = 6;   // wide enough for any supported key length

    localparam logic [BYTE_W-1:0] HDR_B0   = 8'hAB;
    localparam logic [BYTE_W-1:0] HDR_B1   = 8'hCD;
    localparam logic [BYTE_W-1:0] FTR_B0   = 8'hDC;
    localparam logic [BYTE_W-1:0] FTR_B1   = 8'hBA;
    localparam logic [BYTE_W-1:0] PAD_BYTE = 8'hFF;

    // Position of the byte being emitted within one item's run.
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;
    localparam step_t STEP_HDR0   = 4'd0;
    localparam step_t STEP_HDR1   = 4'd1;
    localparam step_t STEP_SIZE_L = 4'd2;
    localparam step_t STEP_SIZE_H = 4'd3;
    localparam step_t STEP_DATA   = 4'd4;
    localparam step_t STEP_PAD0   = 4'd5;
    localparam step_t STEP_PAD1   = 4'd6;
    localparam step_t STEP_FTR0   = 4'd7;
    localparam step_t STEP_FTR1   = 4'd8;

    // Start request for the size remainder unit.
    typedef struct packed {
        logic              start;
        logic [SIZE_W-1:0] size;
    } mod_req_t;

    function automatic logic [BYTE_W-1:0] key_byte(input logic [KEY_IDX_W-1:0] idx);
        logic [BYTE_W-1:0] k;
        case (idx[3:0])
            4'd0:    k = 8'h16;
            4'd1:    k = 8'h6C;
            4'd2:    k = 8'h14;
            4'd3:    k = 8'hE6;
            4'd4:    k = 8'h2E;
            4'd5:    k = 8'h91;
            4'd6:    k = 8'h0D;
            4'd7:    k = 8'h40;
            4'd8:    k = 8'h21;
            4'd9:    k = 8'h35;
            4'd10:   k = 8'hD5;
            4'd11:   k = 8'h40;
            4'd12:   k = 8'h13;
            4'd13:   k = 8'h03;
            4'd14:   k = 8'hE9;
            default: k = 8'h80;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

FILE: src/obfuscated_reply_framer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Obfuscated reply framer
// Wraps payload bytes into a frame: header, size, optionally keyed payload,
// padding and footer, one frame byte per cycle on the result channel unless m_ready stalls it.
// ----------------------------------------------------------------------------
// Timing: the first result passes from the item register into the output register.
// Throughput: one result per cycle unless m_ready stalls the output; an item makes its
//   payload byte, after header and size bytes if first, then padding and footer if last.
//   Each frame byte passes through the single-byte output register.
// Reset (aresetn low, synchronous): drop any held item and result, key position,
//   latched size remainder and obfuscation enable go to zero.
module obfuscated_reply_framer_core #(
    parameter int KEY_LEN = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // configuration
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    // input channel
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_first_byte,
    input  wire logic       s_last_byte,
    input  wire logic [15:0] s_payload_size,
    // result channel
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_run_last,
    output logic            m_frame_end
);

    localparam int KW = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;
    localparam logic [KW-1:0] KEY_LAST = KW'(KEY_LEN - 1);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic obf_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obf_en_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            obf_en_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Item register: one accepted item plus the step it is emitting
    // ------------------------------------------------------------------
    logic                 item_valid_reg;
    orf_pkg::step_t       step_reg;
    logic                 item_last_reg;
    logic [7:0]           data_x_reg;
    logic [15:0]          size_reg;
    logic [KW-1:0]        kpos_reg;

    logic                 out_free;
    logic                 emit;
    logic                 item_done;
    logic                 accept;
    orf_pkg::step_t       step_end;
    logic [KW-1:0]        kidx_cur;
    logic [KW-1:0]        kpos_next;
    logic [7:0]           data_x;

    // The output register can take a byte when empty or being drained.
    assign out_free  = !m_valid || m_ready;
    assign emit      = item_valid_reg && out_free;
    assign step_end  = item_last_reg ? orf_pkg::STEP_FTR1 : orf_pkg::STEP_DATA;
    assign item_done = emit && (step_reg == step_end);

    // Take a new item when the slot is empty or its last byte leaves now.
    assign s_ready = !item_valid_reg || item_done;
    assign accept  = s_valid && s_ready;

    // A first byte restarts the key at position zero.
    assign kidx_cur  = s_first_byte ? '0 : kpos_reg;
    assign kpos_next = (kidx_cur == KEY_LAST) ? '0 : kidx_cur + 1'b1;
    assign data_x    = obf_en_reg
                     ? (s_data_byte ^ orf_pkg::key_byte(orf_pkg::KEY_IDX_W'(kidx_cur)))
                     : s_data_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            step_reg       <= orf_pkg::STEP_DATA;
            kpos_reg       <= '0;
        end else if (accept) begin
            item_valid_reg <= 1'b1;
            step_reg       <= s_first_byte ? orf_pkg::STEP_HDR0 : orf_pkg::STEP_DATA;
            kpos_reg       <= kpos_next;
        end else if (item_done) begin
            item_valid_reg <= 1'b0;
        end else if (emit) begin
            step_reg <= step_reg + 1'b1;
        end
    end

    // Payload of the item: no reset needed.
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_last_reg <= s_last_byte;
            data_x_reg    <= data_x;
            size_reg      <= s_payload_size;
        end
    end

    // ------------------------------------------------------------------
    // Declared size modulo key length, latched per frame. The header
    // bytes give the unit time to finish before padding needs it.
    // ------------------------------------------------------------------
    orf_pkg::mod_req_t mod_req;
    logic [KW-1:0]     size_low;
    logic              mod_busy;

    assign mod_req.start = accept && s_first_byte;
    assign mod_req.size  = s_payload_size;

    orf_size_mod #(
        .KEY_LEN (KEY_LEN)
    ) u_size_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .rem     (size_low),
        .busy    (mod_busy)
    );

    // ------------------------------------------------------------------
    // Frame byte select
    // ------------------------------------------------------------------
    logic [KW-1:0] size_low_inc;
    logic [7:0]    pad0;
    logic [7:0]    pad1;
    logic [7:0]    frame_byte;

    assign size_low_inc = (size_low == KEY_LAST) ? '0 : size_low + 1'b1;
    assign pad0 = obf_en_reg
                ? (orf_pkg::key_byte(orf_pkg::KEY_IDX_W'(size_low)) ^ orf_pkg::PAD_BYTE)
                : orf_pkg::PAD_BYTE;
    assign pad1 = obf_en_reg
                ? (orf_pkg::key_byte(orf_pkg::KEY_IDX_W'(size_low_inc)) ^ orf_pkg::PAD_BYTE)
                : orf_pkg::PAD_BYTE;

    always_comb begin
        unique case (step_reg)
            orf_pkg::STEP_HDR0:   frame_byte = orf_pkg::HDR_B0;
            orf_pkg::STEP_HDR1:   frame_byte = orf_pkg::HDR_B1;
            orf_pkg::STEP_SIZE_L: frame_byte = size_reg[7:0];
            orf_pkg::STEP_SIZE_H: frame_byte = size_reg[15:8];
            orf_pkg::STEP_DATA:   frame_byte = data_x_reg;
            orf_pkg::STEP_PAD0:   frame_byte = pad0;
            orf_pkg::STEP_PAD1:   frame_byte = pad1;
            orf_pkg::STEP_FTR0:   frame_byte = orf_pkg::FTR_B0;
            orf_pkg::STEP_FTR1:   frame_byte = orf_pkg::FTR_B1;
            default:              frame_byte = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic       m_valid_reg;
    logic [7:0] m_byte_reg;
    logic       m_run_last_reg;
    logic       m_frame_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_byte_reg      <= frame_byte;
            m_run_last_reg  <= (step_reg == step_end);
            m_frame_end_reg <= (step_reg == orf_pkg::STEP_FTR1);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = m_byte_reg;
    assign m_run_last  = m_run_last_reg;
    assign m_frame_end = m_frame_end_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTH
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid_reg |-> (step_reg <= orf_pkg::STEP_FTR1))
        else $error("step counter beyond footer");

    a_pad_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && (step_reg == orf_pkg::STEP_PAD0)) |-> !mod_busy)
        else $error("padding emitted before size remainder settled");

    a_no_take_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid_reg && m_valid && !m_ready) |-> !s_ready)
        else $error("item taken while held item is stalled");

    a_frame_end_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_end) |-> (m_run_last && (m_out_byte == orf_pkg::FTR_B1)))
        else $error("frame end not on final footer byte");

    a_result_follows_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !$past(!aresetn)) |=> m_valid)
        else $error("emitted byte lost");
`endif

endmodule
`default_nettype wire

FILE: src/orf_size_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Size remainder unit
// Reduces the declared size modulo the key length by reciprocal
// multiplication: the quotient is registered first, then the remainder.
// ----------------------------------------------------------------------------
module orf_size_mod #(
    parameter int KEY_LEN = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire orf_pkg::mod_req_t      req,
    output logic [((KEY_LEN > 1) ? $clog2(KEY_LEN) : 1)-1:0] rem,
    output logic                        busy
);

    localparam int KW    = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;
    localparam int SW    = orf_pkg::SIZE_W;
    localparam int SH    = SW + KW;
    localparam int P_W   = SH + SW;
    // Reciprocal rounded up: exact quotient for every size below 2**SW
    localparam int RECIP = ((1 << SH) + KEY_LEN - 1) / KEY_LEN;

    logic [KW-1:0]  rem_reg;
    logic [SW-1:0]  size_reg;
    logic [SW-1:0]  quot_reg;
    logic [1:0]     cnt_reg;
    logic [P_W-1:0] prod;
    logic [SW-1:0]  back;
    logic [SW-1:0]  diff;

    // Quotient from the held size, then take back quotient times key length.
    assign prod = P_W'(size_reg) * P_W'(RECIP);
    assign back = SW'(quot_reg * SW'(KEY_LEN));
    assign diff = size_reg - back;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (req.start) begin
            cnt_reg <= 2'd2;
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == 2'd1) begin
                rem_reg <= diff[KW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            size_reg <= req.size;
        end else if (cnt_reg == 2'd2) begin
            quot_reg <= prod[SH +: SW];
        end
    end

    assign rem  = rem_reg;
    assign busy = (cnt_reg != '0);

endmodule
`default_nettype wire
